[src/lanc_pkg.sv]
package lanc_pkg;

   localparam int SAMPLE_W            = 16;
   localparam int STEP_W              = 16;
   localparam int WEIGHT_W            = 48;
   localparam int ACC_W               = 64;
   localparam int STEP_ERR_W          = 33;
   localparam int STEP_SHIFT          = 56;
   localparam int TAPS_DEFAULT        = 30;
   localparam int WEIGHT_FRAC_DEFAULT = 40;

   localparam logic [STEP_W-1:0] STEP_RESET = 16'd7206;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] ref_sample;
      logic signed [SAMPLE_W-1:0] primary_sample;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] error_sample;
      logic signed [SAMPLE_W-1:0] estimate_sample;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      MUL_TAP,
      MUL_STEP,
      MUL_UPD
   } mul_sel_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAC,
      ST_MAC_DRAIN,
      ST_ROUND_A,
      ST_ROUND_B,
      ST_STEP_MUL,
      ST_STEP_WAIT,
      ST_UPD,
      ST_UPD_DRAIN
   } state_type;

   typedef struct packed {
      logic        start;
      logic        rd_en;
      mul_sel_type mul_sel;
      logic        acc_en;
      logic        w_we;
      logic        x_we;
      logic        clr;
      logic        round_a;
      logic        round_b;
      logic        step_load;
      logic        out_load;
   } ctrl_type;

   function automatic logic signed [ACC_W-1:0] sat_add64(input logic signed [ACC_W-1:0] a,
                                                         input logic signed [ACC_W-1:0] b);
      logic signed [ACC_W:0] sum;
      sum = (ACC_W+1)'(a) + (ACC_W+1)'(b);
      if (sum[ACC_W] != sum[ACC_W-1]) begin
         return sum[ACC_W] ? ACC_MIN : ACC_MAX;
      end
      return sum[ACC_W-1:0];
   endfunction

   function automatic logic signed [ACC_W-1:0] sat_sub64(input logic signed [ACC_W-1:0] a,
                                                         input logic signed [ACC_W-1:0] b);
      logic signed [ACC_W:0] diff;
      diff = (ACC_W+1)'(a) - (ACC_W+1)'(b);
      if (diff[ACC_W] != diff[ACC_W-1]) begin
         return diff[ACC_W] ? ACC_MIN : ACC_MAX;
      end
      return diff[ACC_W-1:0];
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
      if (v > 64'sd32767) begin
         return 16'sh7fff;
      end else if (v < -64'sd32768) begin
         return 16'sh8000;
      end
      return v[SAMPLE_W-1:0];
   endfunction

   // Round to nearest with halves toward plus infinity, then clamp to 16 bits.
   function automatic logic signed [SAMPLE_W-1:0] round16(input logic signed [ACC_W-1:0] a,
                                                          input int s);
      logic signed [ACC_W-1:0] t;
      t = sat_add64(a, 64'sd1 <<< (s - 1));
      return sat16(t >>> s);
   endfunction

endpackage

[src/lanc_stream_if.sv]
interface lanc_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[src/lanc_ram.sv]
module lanc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 30
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

[src/lanc_mac.sv]
module lanc_mac
   import lanc_pkg::*;
(
   input  logic                          clock,
   input  mul_sel_type                   mul_sel,
   input  logic signed [WEIGHT_W-1:0]    w_rd,
   input  logic signed [SAMPLE_W-1:0]    x_rd,
   input  logic [STEP_W-1:0]             step,
   input  logic signed [SAMPLE_W-1:0]    err,
   input  logic signed [STEP_ERR_W-1:0]  step_err,
   input  logic                          acc_clr,
   input  logic                          acc_en,
   output logic signed [ACC_W-1:0]       prod_ff,
   output logic signed [ACC_W-1:0]       acc_ff
);

   logic signed [WEIGHT_W-1:0] mul_a;
   logic signed [SAMPLE_W-1:0] mul_b;
   logic signed [ACC_W-1:0]    prod_in;
   logic signed [ACC_W-1:0]    acc_in;

   always_comb begin
      case (mul_sel)
         MUL_TAP: begin
            mul_a = w_rd;
            mul_b = x_rd;
         end
         MUL_STEP: begin
            mul_a = signed'({{(WEIGHT_W-STEP_W){1'b0}}, step});
            mul_b = err;
         end
         MUL_UPD: begin
            mul_a = WEIGHT_W'(step_err);
            mul_b = x_rd;
         end
         default: begin
            mul_a = w_rd;
            mul_b = x_rd;
         end
      endcase
   end

   // The product is formed at full accumulator width; operands stay 48 by 16.
   assign prod_in = mul_a * mul_b;

   always_comb begin
      acc_in = acc_ff;
      if (acc_clr) begin
         acc_in = '0;
      end else if (acc_en) begin
         acc_in = sat_add64(acc_ff, prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

endmodule

[src/lanc_ctrl.sv]
module lanc_ctrl
   import lanc_pkg::*;
#(
   parameter int TAPS = TAPS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    out_free,
   output logic                    req_ready,
   output ctrl_type                ctl,
   output logic [$clog2(TAPS)-1:0] rd_w_addr,
   output logic [$clog2(TAPS)-1:0] rd_x_addr,
   output logic [$clog2(TAPS)-1:0] wr_w_addr,
   output logic [$clog2(TAPS)-1:0] wr_x_addr
);

   localparam int               IDX_W = $clog2(TAPS);
   localparam logic [IDX_W-1:0] LAST  = IDX_W'(TAPS - 1);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] daddr_ff, daddr_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] idx_p1_ff, idx_p2_ff;
   logic             s1_v_ff, s2_v_ff;
   logic             idx_last;

   assign idx_last = (idx_ff == LAST);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:     if (idx_last) state_in = ST_IDLE;
         ST_IDLE:      if (req_valid) state_in = ST_MAC;
         ST_MAC:       if (idx_last) state_in = ST_MAC_DRAIN;
         ST_MAC_DRAIN: if (!s1_v_ff) state_in = ST_ROUND_A;
         ST_ROUND_A:   state_in = ST_ROUND_B;
         ST_ROUND_B:   state_in = ST_STEP_MUL;
         ST_STEP_MUL:  if (out_free) state_in = ST_STEP_WAIT;
         ST_STEP_WAIT: state_in = ST_UPD;
         ST_UPD:       if (idx_last) state_in = ST_UPD_DRAIN;
         ST_UPD_DRAIN: if (!s1_v_ff) state_in = ST_IDLE;
         default:      state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      ctl         = '0;
      ctl.mul_sel = MUL_TAP;
      case (state_ff)
         ST_CLEAR: begin
            ctl.clr  = 1'b1;
            ctl.w_we = 1'b1;
            ctl.x_we = 1'b1;
         end
         ST_IDLE: begin
            ctl.start = req_valid;
            ctl.x_we  = req_valid;
         end
         ST_MAC: begin
            ctl.rd_en  = 1'b1;
            ctl.acc_en = s2_v_ff;
         end
         ST_MAC_DRAIN: begin
            ctl.acc_en = s2_v_ff;
         end
         ST_ROUND_A: begin
            ctl.round_a = 1'b1;
         end
         ST_ROUND_B: begin
            ctl.round_b = 1'b1;
         end
         ST_STEP_MUL: begin
            ctl.mul_sel  = MUL_STEP;
            ctl.out_load = out_free;
         end
         ST_STEP_WAIT: begin
            ctl.step_load = 1'b1;
         end
         ST_UPD: begin
            ctl.rd_en   = 1'b1;
            ctl.mul_sel = MUL_UPD;
            ctl.w_we    = s2_v_ff;
         end
         ST_UPD_DRAIN: begin
            ctl.mul_sel = MUL_UPD;
            ctl.w_we    = s2_v_ff;
         end
         default: begin
            ctl = '0;
         end
      endcase
   end

   // The delay line is circular: tap i sits at head minus i, so a shift is
   // just a step of the head once the item is done.
   always_comb begin
      idx_in   = idx_ff;
      daddr_in = daddr_ff;
      head_in  = head_ff;
      case (state_ff)
         ST_CLEAR: begin
            idx_in = idx_last ? '0 : idx_ff + IDX_W'(1);
         end
         ST_IDLE, ST_STEP_WAIT: begin
            idx_in   = '0;
            daddr_in = head_ff;
         end
         ST_MAC, ST_UPD: begin
            idx_in   = idx_last ? '0 : idx_ff + IDX_W'(1);
            daddr_in = (daddr_ff == '0) ? LAST : daddr_ff - IDX_W'(1);
         end
         ST_UPD_DRAIN: begin
            if (!s1_v_ff) begin
               head_in = (head_ff == LAST) ? '0 : head_ff + IDX_W'(1);
            end
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         idx_ff   <= '0;
         head_ff  <= '0;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         head_ff  <= head_in;
         s1_v_ff  <= ctl.rd_en;
         s2_v_ff  <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      daddr_ff  <= daddr_in;
      idx_p1_ff <= idx_ff;
      idx_p2_ff <= idx_p1_ff;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rd_w_addr = idx_ff;
   assign rd_x_addr = daddr_ff;
   assign wr_w_addr = ctl.clr ? idx_ff : idx_p2_ff;
   assign wr_x_addr = ctl.clr ? idx_ff : head_ff;

`ifndef SYNTHESIS
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!s1_v_ff && !s2_v_ff))
      else $error("pipeline not empty while waiting for an item");

   a_no_rmw_overlap: assert property (@(posedge clock) disable iff (reset)
      (ctl.w_we && ctl.rd_en) |-> (wr_w_addr != rd_w_addr))
      else $error("weight write collides with a weight read");

   a_result_before_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP_WAIT) |-> $past(ctl.out_load))
      else $error("update started before the result was loaded");

   a_head_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> $stable(head_ff))
      else $error("delay head moved during an item");

   a_head_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= LAST)
      else $error("delay head out of range");
`endif

endmodule

[src/lms_adaptive_noise_canceller.sv]
// LMS adaptive FIR noise canceller. Each item on req_chan carries a reference
// noise sample and a primary sample; the block answers with one item on
// rsp_chan holding the error (primary minus filter estimate) and the estimate,
// both rounded and saturated to 16 bits, and then adapts every weight by
// step_size * 2^-56 * error * tap sample. Weights and delayed samples live in
// two single-port-read RAMs with registered read data, and one shared
// 48x16 multiplier serves the filter pass, the step-times-error product and
// the update pass. An item passes through one filter pass of TAPS reads, two
// rounding steps, the step product and one read-modify-write pass of TAPS
// entries, each pass followed by a pipeline drain. The result is loaded for
// output in the step-product state; the block waits there, before its update
// pass, while an earlier result is still untaken. After reset a clearing pass
// over all TAPS entries zeroes both RAMs before the first item is
// taken. csr_wr_en/csr_wr_data write the step mantissa and should only be
// used while the block is idle.
module lms_adaptive_noise_canceller
   import lanc_pkg::*;
#(
   parameter int TAPS             = TAPS_DEFAULT,
   parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   lanc_stream_if.sink         req_chan,
   lanc_stream_if.source       rsp_chan,
   input  logic                csr_wr_en,
   input  logic [STEP_W-1:0]   csr_wr_data
);

   localparam int IDX_W     = $clog2(TAPS);
   localparam int UPD_SHIFT = STEP_SHIFT - WEIGHT_FRAC_BITS;

   localparam logic signed [ACC_W-1:0] W_MAX = (64'sd1 <<< (WEIGHT_W - 1)) - 64'sd1;
   localparam logic signed [ACC_W-1:0] W_MIN = -W_MAX - 64'sd1;
   localparam logic signed [ACC_W-1:0] UPD_HALF = 64'sd1 <<< (UPD_SHIFT - 1);

   ctrl_type         ctl;
   logic             req_ready;
   logic             out_free;
   logic [IDX_W-1:0] rd_w_addr, rd_x_addr, wr_w_addr, wr_x_addr;

   logic [WEIGHT_W-1:0]           w_rd_raw, w_wdata;
   logic [SAMPLE_W-1:0]           x_rd_raw, x_wdata;
   logic signed [ACC_W-1:0]       prod_ff, acc_ff;

   logic [STEP_W-1:0]             step_ff;
   logic signed [SAMPLE_W-1:0]    primary_ff;
   logic signed [ACC_W-1:0]       efix_ff;
   logic signed [SAMPLE_W-1:0]    est_ff, err_ff;
   logic signed [STEP_ERR_W-1:0]  step_err_ff;
   logic signed [WEIGHT_W-1:0]    w_pipe_ff;
   logic                          rsp_valid_ff;
   rsp_payload_type               rsp_data_ff;

   logic signed [ACC_W-1:0]       delta, wsum;
   logic signed [WEIGHT_W-1:0]    w_new;

   lanc_ctrl #(.TAPS(TAPS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .out_free  (out_free),
      .req_ready (req_ready),
      .ctl       (ctl),
      .rd_w_addr (rd_w_addr),
      .rd_x_addr (rd_x_addr),
      .wr_w_addr (wr_w_addr),
      .wr_x_addr (wr_x_addr)
   );

   lanc_ram #(.WIDTH(WEIGHT_W), .DEPTH(TAPS)) u_weight_ram (
      .clock (clock),
      .we    (ctl.w_we),
      .waddr (wr_w_addr),
      .wdata (w_wdata),
      .re    (ctl.rd_en),
      .raddr (rd_w_addr),
      .rdata (w_rd_raw)
   );

   lanc_ram #(.WIDTH(SAMPLE_W), .DEPTH(TAPS)) u_delay_ram (
      .clock (clock),
      .we    (ctl.x_we),
      .waddr (wr_x_addr),
      .wdata (x_wdata),
      .re    (ctl.rd_en),
      .raddr (rd_x_addr),
      .rdata (x_rd_raw)
   );

   lanc_mac u_mac (
      .clock    (clock),
      .mul_sel  (ctl.mul_sel),
      .w_rd     (signed'(w_rd_raw)),
      .x_rd     (signed'(x_rd_raw)),
      .step     (step_ff),
      .err      (err_ff),
      .step_err (step_err_ff),
      .acc_clr  (ctl.start),
      .acc_en   (ctl.acc_en),
      .prod_ff  (prod_ff),
      .acc_ff   (acc_ff)
   );

   assign x_wdata = ctl.clr ? '0 : req_chan.payload.ref_sample;

   // Weight update: round the step product down to weight precision, add,
   // and clamp to the weight range.
   always_comb begin
      delta = (prod_ff + UPD_HALF) >>> UPD_SHIFT;
      wsum  = ACC_W'(w_pipe_ff) + delta;
      if (wsum > W_MAX) begin
         w_new = WEIGHT_W'(W_MAX);
      end else if (wsum < W_MIN) begin
         w_new = WEIGHT_W'(W_MIN);
      end else begin
         w_new = WEIGHT_W'(wsum);
      end
   end

   assign w_wdata  = ctl.clr ? '0 : w_new;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            step_ff <= csr_wr_data;
         end
         if (ctl.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      w_pipe_ff <= signed'(w_rd_raw);
      if (ctl.start) begin
         primary_ff <= req_chan.payload.primary_sample;
      end
      if (ctl.round_a) begin
         efix_ff <= sat_sub64(ACC_W'(primary_ff) <<< WEIGHT_FRAC_BITS, acc_ff);
         est_ff  <= round16(acc_ff, WEIGHT_FRAC_BITS);
      end
      if (ctl.round_b) begin
         err_ff <= round16(efix_ff, WEIGHT_FRAC_BITS);
      end
      if (ctl.step_load) begin
         step_err_ff <= prod_ff[STEP_ERR_W-1:0];
      end
      if (ctl.out_load) begin
         rsp_data_ff.error_sample    <= err_ff;
         rsp_data_ff.estimate_sample <= est_ff;
      end
   end

   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

endmodule

[tb/tb_lms_adaptive_noise_canceller.sv]
`timescale 1ns / 100ps

module tb_lms_adaptive_noise_canceller;
   import lanc_pkg::*;

   localparam int TAPS = TAPS_DEFAULT;
   localparam int FRAC = WEIGHT_FRAC_DEFAULT;
   localparam int SETTLE_CYCLES = 2*TAPS + 20;
   localparam longint LONG_MAX = 64'sh7fff_ffff_ffff_ffff;
   localparam longint LONG_MIN = 64'sh8000_0000_0000_0000;
   localparam longint COEF_MAX = 64'sh0000_7fff_ffff_ffff;
   localparam longint COEF_MIN = -COEF_MAX - 1;
   localparam int NUM_BLOCKS = 10;
   localparam int BLOCK_ITEMS = 200;

   typedef enum int {PAT_NOISE, PAT_ECHO, PAT_CORNER, PAT_SWING} pattern_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [STEP_W-1:0] csr_wr_data;

   lanc_stream_if #(.payload_type(req_payload_type)) req_if ();
   lanc_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   lms_adaptive_noise_canceller uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   // Predictor state: weights, delayed reference samples and the step mantissa.
   longint            tap_coef[TAPS] = '{default: 0};
   logic signed [15:0] tap_hist[TAPS] = '{default: 0};
   logic [STEP_W-1:0]  adapt_step = STEP_RESET;

   req_payload_type noise_items[$];
   rsp_payload_type predicted_outputs[$];
   int  mismatch_count = 0;
   bit  idle_on = 1'b1;

   function automatic longint add_sat(longint a, longint b);
      longint s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         return a[63] ? LONG_MIN : LONG_MAX;
      end
      return s;
   endfunction

   function automatic longint sub_sat(longint a, longint b);
      longint s;
      s = a - b;
      if (a[63] != b[63] && s[63] != a[63]) begin
         return a[63] ? LONG_MIN : LONG_MAX;
      end
      return s;
   endfunction

   // Round half toward plus infinity, then floor shift.
   function automatic longint round_shr(longint a, int s);
      longint t;
      t = add_sat(a, longint'(1) <<< (s - 1));
      return t >>> s;
   endfunction

   function automatic logic signed [15:0] clamp16(longint v);
      if (v > 32767) begin
         return 16'sh7fff;
      end else if (v < -32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   function automatic rsp_payload_type cancel_noise(req_payload_type item);
      longint acc;
      longint err_fix;
      longint prod;
      longint w;
      rsp_payload_type r;
      int i;
      tap_hist[0] = item.ref_sample;
      acc = 0;
      for (i = 0; i < TAPS; i++) begin
         acc = add_sat(acc, tap_coef[i] * longint'(tap_hist[i]));
      end
      err_fix = sub_sat(longint'(item.primary_sample) <<< FRAC, acc);
      r.estimate_sample = clamp16(round_shr(acc, FRAC));
      r.error_sample = clamp16(round_shr(err_fix, FRAC));
      // The update uses the samples before the shift, so walk from the far end.
      for (i = TAPS - 1; i >= 0; i--) begin
         prod = longint'(adapt_step) * longint'(r.error_sample) * longint'(tap_hist[i]);
         w = tap_coef[i] + round_shr(prod, STEP_SHIFT - FRAC);
         if (w > COEF_MAX) begin
            w = COEF_MAX;
         end else if (w < COEF_MIN) begin
            w = COEF_MIN;
         end
         tap_coef[i] = w;
         tap_hist[i] = (i > 0) ? tap_hist[i-1] : 16'sd0;
      end
      return r;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      if (!idle_on) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return $urandom_range(0, 3);
      end else if (r < 95) begin
         return $urandom_range(4, 20);
      end
      return $urandom_range(40, 200);
   endfunction

   function automatic int clip16(int v);
      if (v > 32767) begin
         return 32767;
      end else if (v < -32768) begin
         return -32768;
      end
      return v;
   endfunction

   function automatic int rand_full();
      logic signed [15:0] v;
      v = 16'($urandom_range(0, 65535));
      return int'(v);
   endfunction

   function automatic int corner_value();
      case ($urandom_range(0, 5))
         0: return -32768;
         1: return 32767;
         2: return 0;
         3: return -1;
         4: return 1;
         default: return rand_full();
      endcase
   endfunction

   task automatic queue_item(int ref_val, int pri_val);
      req_payload_type it;
      it.ref_sample = ref_val[15:0];
      it.primary_sample = pri_val[15:0];
      noise_items.push_back(it);
   endtask

   task automatic wait_drained();
      while (noise_items.size() != 0 || req_if.valid || predicted_outputs.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The block must be idle; the sender holds off until all results are back.
   task automatic write_step(logic [STEP_W-1:0] value);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      adapt_step = value;
   endtask

   always @(posedge clock) begin : driver
      int send_gap;
      bit accepted;
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap = 0;
      end else begin
         accepted = req_if.valid && req_if.ready;
         if (accepted) begin
            predicted_outputs.push_back(cancel_noise(req_if.payload));
         end
         if (!req_if.valid || accepted) begin
            if (send_gap > 0) begin
               send_gap--;
               req_if.valid <= 1'b0;
            end else if (noise_items.size() != 0) begin
               req_if.valid <= 1'b1;
               req_if.payload <= noise_items.pop_front();
               send_gap = pick_gap();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      int stall_left;
      rsp_payload_type want;
      rsp_payload_type got;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            if (predicted_outputs.size() == 0) begin
               $display("%0t: unexpected item error=%0d estimate=%0d", $time,
                        got.error_sample, got.estimate_sample);
               mismatch_count++;
            end else begin
               want = predicted_outputs.pop_front();
               if (got.error_sample !== want.error_sample) begin
                  $display("%0t: error_sample expected %0d actual %0d", $time,
                           want.error_sample, got.error_sample);
                  mismatch_count++;
               end
               if (got.estimate_sample !== want.estimate_sample) begin
                  $display("%0t: estimate_sample expected %0d actual %0d", $time,
                           want.estimate_sample, got.estimate_sample);
                  mismatch_count++;
               end
            end
         end
         if (stall_left == 0 && $urandom_range(0, 31) == 0) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      logic [STEP_W-1:0] step_plan[NUM_BLOCKS];
      pattern_type       block_pattern[NUM_BLOCKS];
      pattern_type       kind;
      int r1;
      int r2;
      int ref_val;
      int pri_val;
      int blk;
      int n;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Field extremes and bit patterns with the step left at its reset value.
      queue_item(0, 0);
      queue_item(32767, 32767);
      queue_item(-32768, -32768);
      queue_item(32767, -32768);
      queue_item(-32768, 32767);
      queue_item(21845, -21846);
      queue_item(-21846, 21845);
      queue_item(1, -1);
      queue_item(-1, 1);

      // Largest step: build up the weights, then push the error into saturation.
      write_step(16'hffff);
      repeat (12) queue_item(32767, 32767);
      queue_item(32767, -32768);
      queue_item(-32768, 32767);
      queue_item(-32768, -32768);

      step_plan = '{16'hffff, 16'h0000, STEP_RESET, 16'h0001, 16'h8000,
                    16'hffff, 16'h0000, 16'hffff, 16'h1000, STEP_RESET};
      step_plan[6] = STEP_W'($urandom_range(0, 65535));
      block_pattern = '{PAT_SWING, PAT_ECHO, PAT_ECHO, PAT_NOISE, PAT_ECHO,
                        PAT_SWING, PAT_CORNER, PAT_SWING, PAT_ECHO, PAT_ECHO};
      r1 = 0;
      r2 = 0;
      for (blk = 0; blk < NUM_BLOCKS; blk++) begin
         write_step(step_plan[blk]);
         idle_on = (blk % 3 != 1);
         for (n = 0; n < BLOCK_ITEMS; n++) begin
            kind = block_pattern[blk];
            if ($urandom_range(0, 9) < 2) begin
               kind = $urandom_range(0, 1) ? PAT_NOISE : PAT_CORNER;
            end
            case (kind)
               PAT_ECHO: begin
                  ref_val = rand_full();
                  pri_val = clip16(r1/2 + r2/4 + int'($urandom_range(0, 2000)) - 1000);
               end
               PAT_SWING: begin
                  ref_val = $urandom_range(0, 1) ? 32767 : -32768;
                  pri_val = clip16(-r1);
               end
               PAT_CORNER: begin
                  ref_val = corner_value();
                  pri_val = corner_value();
               end
               default: begin
                  ref_val = rand_full();
                  pri_val = rand_full();
               end
            endcase
            queue_item(ref_val, pri_val);
            r2 = r1;
            r1 = ref_val;
         end
      end

      wait_drained();
      if (mismatch_count == 0 && predicted_outputs.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin : watchdog
      #50_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

[lms_adaptive_noise_canceller.f]
src/lanc_pkg.sv
src/lanc_stream_if.sv
src/lanc_ram.sv
src/lanc_mac.sv
src/lanc_ctrl.sv
src/lms_adaptive_noise_canceller.sv
tb/tb_lms_adaptive_noise_canceller.sv
